FILE: rtl/core/drbf_pkg.sv
package drbf_pkg;

   // Field widths of the request and response channels.
   localparam int OPCODE_W = 3;
   localparam int BYTE_W   = 8;
   localparam int AMOUNT_W = 9;
   localparam int FILL_W   = 9;
   localparam int SIZE_W   = 9;
   localparam int ERR_W    = 2;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_STATUS = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SIZE   = 3'd4;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_REFUSED  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_DELIM = 2'd2;

   // Register file.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_MARGIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER   = 1'b1;

   localparam logic [BYTE_W-1:0] FULL_MARGIN_RESET = 8'd8;
   localparam logic [BYTE_W-1:0] DELIMITER_RESET   = 8'd0;

endpackage

FILE: rtl/core/drbf_ram.sv
module drbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/drbf_scan.sv
module drbf_scan #(
   parameter int CAPACITY = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [$clog2(CAPACITY)-1:0]       start_ptr,
   input  logic [$clog2(CAPACITY+1)-1:0]     length,
   input  logic [drbf_pkg::BYTE_W-1:0]       delimiter,
   input  logic [drbf_pkg::BYTE_W-1:0]       rdata,
   output logic [$clog2(CAPACITY)-1:0]       raddr,
   output logic                              done,
   output logic [$clog2(CAPACITY+1)-1:0]     count,
   output logic [$clog2(CAPACITY+1)-1:0]     first
);

   import drbf_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);

   logic             active_ff, active_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [CNT_W-1:0] pend_off_ff, pend_off_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [PTR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] first_ff, first_in;

   // The read for offset n is issued in one cycle and compared in the next,
   // so the scan is done once every offset is issued and nothing is pending.
   assign done = active_ff && (issue_ff == len_ff) && !pend_ff;

   always_comb begin
      active_in   = active_ff;
      pend_in     = 1'b0;
      issue_in    = issue_ff;
      pend_off_in = pend_off_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      if (start) begin
         active_in = 1'b1;
         issue_in  = '0;
         len_in    = length;
         addr_in   = start_ptr;
         count_in  = '0;
         first_in  = '0;
      end else if (active_ff) begin
         if (issue_ff != len_ff) begin
            pend_in     = 1'b1;
            pend_off_in = issue_ff;
            issue_in    = issue_ff + 1'b1;
            addr_in     = (addr_ff == PTR_LAST) ? '0 : addr_ff + 1'b1;
         end
         if (pend_ff && (rdata == delimiter)) begin
            count_in = count_ff + 1'b1;
            if (first_ff == '0) begin
               first_in = pend_off_ff + 1'b1;
            end
         end
         if (done) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
      issue_ff    <= issue_in;
      pend_off_ff <= pend_off_in;
      len_ff      <= len_in;
      addr_ff     <= addr_in;
      count_ff    <= count_in;
      first_ff    <= first_in;
   end

   assign raddr = addr_ff;
   assign count = count_ff;
   assign first = first_ff;

endmodule

FILE: rtl/core/delimited_receive_ring_buffer.sv
// Byte receive ring buffer with packet-delimiter tracking.
// An item is a command on req_opcode (push, pop, clear, status, packet size),
// accepted at a clock edge where start is high and busy is low. Each item
// gives at most one result, shown on the rsp_ ports for one cycle with
// rsp_valid high, in the cycle after the item finishes; the receiver takes
// it at that cycle's closing edge and cannot hold it off.
// Push, status, refusals, a clear of zero bytes and the unused opcodes finish
// at acceptance: busy stays low and a new item can follow in the next cycle.
// A pop passes through the pop state, as the byte store's read is registered.
// Clear and packet size recount the held bytes through the store's single
// read port, one byte per cycle. A delimiter register write outside a pop
// starts the same recount, restarting one under way (a clear or packet
// size cut short gives none); busy is high from the write until it ends.
// The register port (csr_) holds full_margin at byte address 0 and
// delimiter_value at byte address 4; pready is always high.
// Synchronous reset empties the buffer, clears the overflow flag and loads
// the register defaults; the byte store itself is not cleared, as only
// bytes that were pushed are ever read.
module delimited_receive_ring_buffer #(
   parameter int CAPACITY = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [drbf_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [drbf_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic [drbf_pkg::AMOUNT_W-1:0]        req_amount,
   output logic                                 rsp_valid,
   output logic [drbf_pkg::BYTE_W-1:0]          rsp_read_byte,
   output logic                                 rsp_is_delimiter,
   output logic [drbf_pkg::FILL_W-1:0]          rsp_fill_count,
   output logic                                 rsp_new_packet,
   output logic                                 rsp_full_flag,
   output logic                                 rsp_overflow_flag,
   output logic [drbf_pkg::SIZE_W-1:0]          rsp_packet_size,
   output logic [drbf_pkg::ERR_W-1:0]           rsp_error_code,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [drbf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [drbf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [drbf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   import drbf_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;
   localparam int SUM_W = CNT_W + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN
   } state_type;

   typedef enum logic [1:0] {
      KIND_RECOUNT,
      KIND_CLEAR,
      KIND_SIZE
   } kind_type;

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [BYTE_W-1:0] margin_ff, margin_in;
   logic [BYTE_W-1:0] delim_ff, delim_in;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_isdel_ff;
   logic [FILL_W-1:0] rsp_fill_ff;
   logic              rsp_newpkt_ff;
   logic              rsp_full_ff;
   logic              rsp_ovf_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [ERR_W-1:0]  rsp_err_ff;

   logic              finish;
   logic [BYTE_W-1:0] res_byte;
   logic              res_isdel;
   logic [CNT_W-1:0]  res_size;
   logic [ERR_W-1:0]  res_err;

   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   delim_write;
   logic                   accept;

   logic              ram_we;
   logic [PTR_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic             scan_start;
   logic [PTR_W-1:0] scan_ptr;
   logic [CNT_W-1:0] scan_len;
   logic [PTR_W-1:0] scan_raddr;
   logic             scan_done;
   logic [CNT_W-1:0] scan_count;
   logic [CNT_W-1:0] scan_first;

   logic [CMP_W-1:0] amount_w;
   logic [CMP_W-1:0] fill_w;
   logic [CNT_W-1:0] amount_sat;
   logic [SUM_W-1:0] rp_sum;
   logic [PTR_W-1:0] rp_cleared;
   logic [CNT_W-1:0] free_space;
   logic             full_next;

   // Register port.
   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite;
   assign csr_index   = csr_paddr[CSR_ADDR_W-1:2];
   assign delim_write = csr_write && (csr_index == CSR_DELIMITER);

   always_comb begin
      case (csr_index)
         CSR_FULL_MARGIN: csr_prdata = CSR_DATA_W'(margin_ff);
         CSR_DELIMITER:   csr_prdata = CSR_DATA_W'(delim_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      margin_in = margin_ff;
      delim_in  = delim_ff;
      if (csr_write && (csr_index == CSR_FULL_MARGIN)) begin
         margin_in = csr_pwdata[BYTE_W-1:0];
      end
      if (delim_write) begin
         delim_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   // A delimiter write holds off a new item for the cycle it lands in.
   assign busy   = (state_ff != ST_IDLE) || delim_write;
   assign accept = start && !busy;

   // Clear amount saturated to the fill level, and the read pointer after it.
   assign amount_w   = CMP_W'(req_amount);
   assign fill_w     = CMP_W'(fill_ff);
   assign amount_sat = CNT_W'((amount_w > fill_w) ? fill_w : amount_w);
   assign rp_sum     = SUM_W'(rp_ff) + SUM_W'(amount_sat);
   assign rp_cleared = PTR_W'((rp_sum >= CAP_SUM) ? rp_sum - CAP_SUM : rp_sum);

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      finish     = 1'b0;
      res_byte   = '0;
      res_isdel  = 1'b0;
      res_size   = '0;
      res_err    = ERR_NONE;
      ram_we     = 1'b0;
      scan_start = 1'b0;
      scan_ptr   = rp_ff;
      scan_len   = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (delim_write) begin
               scan_start = 1'b1;
               kind_in    = KIND_RECOUNT;
               state_in   = ST_SCAN;
            end else if (accept) begin
               case (req_opcode)
                  OP_PUSH: begin
                     finish = 1'b1;
                     if (fill_ff == CAP_CNT) begin
                        ovf_in  = 1'b1;
                        res_err = ERR_REFUSED;
                     end else begin
                        ram_we  = 1'b1;
                        wp_in   = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
                        fill_in = fill_ff + 1'b1;
                        if (req_data_byte == delim_ff) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  OP_POP: begin
                     if (fill_ff == '0) begin
                        finish  = 1'b1;
                        res_err = ERR_REFUSED;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  OP_CLEAR: begin
                     if (amount_sat == '0) begin
                        finish = 1'b1;
                     end else begin
                        rp_in      = rp_cleared;
                        fill_in    = fill_ff - amount_sat;
                        ovf_in     = 1'b0;
                        scan_start = 1'b1;
                        scan_ptr   = rp_cleared;
                        scan_len   = fill_ff - amount_sat;
                        kind_in    = KIND_CLEAR;
                        state_in   = ST_SCAN;
                     end
                  end
                  OP_SIZE: begin
                     scan_start = 1'b1;
                     kind_in    = KIND_SIZE;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            finish   = 1'b1;
            res_byte = ram_rdata;
            rp_in    = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
            fill_in  = fill_ff - 1'b1;
            ovf_in   = 1'b0;
            if (ram_rdata == delim_ff) begin
               res_isdel = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (delim_write) begin
               // A new delimiter restarts the recount from the top.
               scan_start = 1'b1;
               kind_in    = KIND_RECOUNT;
            end else if (scan_done) begin
               count_in = scan_count;
               state_in = ST_IDLE;
               if (kind_ff != KIND_RECOUNT) begin
                  finish = 1'b1;
               end
               if (kind_ff == KIND_SIZE) begin
                  res_size = scan_first;
                  res_err  = (scan_first == '0) ? ERR_NO_DELIM : ERR_NONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign free_space = CAP_CNT - fill_in;
   assign full_next  = CMP_W'(free_space) <= CMP_W'(margin_ff);

   // The store is read at the read pointer while idle, ready for a pop.
   assign ram_raddr = (state_ff == ST_IDLE) ? rp_ff : scan_raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_RECOUNT;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         margin_ff    <= FULL_MARGIN_RESET;
         delim_ff     <= DELIMITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         margin_ff    <= margin_in;
         delim_ff     <= delim_in;
         rsp_valid_ff <= finish;
      end
      if (finish) begin
         rsp_byte_ff   <= res_byte;
         rsp_isdel_ff  <= res_isdel;
         rsp_fill_ff   <= FILL_W'(fill_in);
         rsp_newpkt_ff <= (count_in != '0);
         rsp_full_ff   <= full_next;
         rsp_ovf_ff    <= ovf_in;
         rsp_size_ff   <= SIZE_W'(res_size);
         rsp_err_ff    <= res_err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_is_delimiter  = rsp_isdel_ff;
   assign rsp_fill_count    = rsp_fill_ff;
   assign rsp_new_packet    = rsp_newpkt_ff;
   assign rsp_full_flag     = rsp_full_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;
   assign rsp_packet_size   = rsp_size_ff;
   assign rsp_error_code    = rsp_err_ff;

   drbf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (req_data_byte),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   drbf_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .start_ptr (scan_ptr),
      .length    (scan_len),
      .delimiter (delim_ff),
      .rdata     (ram_rdata),
      .raddr     (scan_raddr),
      .done      (scan_done),
      .count     (scan_count),
      .first     (scan_first)
   );

endmodule

FILE: rtl/core/drbf_checker.sv
module drbf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [drbf_pkg::OPCODE_W-1:0] req_opcode,
   input logic                          rsp_valid,
   input logic [drbf_pkg::BYTE_W-1:0]   rsp_read_byte,
   input logic                          rsp_is_delimiter,
   input logic [drbf_pkg::SIZE_W-1:0]   rsp_packet_size,
   input logic [drbf_pkg::ERR_W-1:0]    rsp_error_code
);

   import drbf_pkg::*;

   // After reset no transfer is pending and the block is ready.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy right after reset");

   // A status request always completes in the very next cycle.
   a_status_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_STATUS) |=> rsp_valid)
      else $error("status result not delivered in the next cycle");

   a_error_code_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == ERR_NONE) || (rsp_error_code == ERR_REFUSED)
                    || (rsp_error_code == ERR_NO_DELIM))
      else $error("undefined error code");

   a_size_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_packet_size != '0) |-> rsp_error_code == ERR_NONE)
      else $error("packet size reported together with an error");

   // A popped byte never comes with a packet size or an error.
   a_pop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_delimiter || (rsp_read_byte != '0))
      |-> (rsp_error_code == ERR_NONE) && (rsp_packet_size == '0))
      else $error("popped byte reported with an error or a size");

endmodule

bind delimited_receive_ring_buffer drbf_checker u_checker (.*);
